// ----- hdl/tclt_pkg.sv -----
// Package for the command line tokenizer: keyword table, role and command codes.
`timescale 1ns / 1ps

package tclt_pkg;

    localparam int unsigned KwCount  = 8;
    localparam int unsigned KwMaxLen = 11;

    typedef logic [KwCount-1:0] t_kw_mask;

    typedef enum logic [1:0] {
        ROLE_COMMAND = 2'd0,
        ROLE_KEY     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_SPACE   = 2'd3
    } t_role;

    typedef enum logic [3:0] {
        CMD_INVALID     = 4'd0,
        CMD_GET         = 4'd1,
        CMD_SET         = 4'd2,
        CMD_DEL         = 4'd3,
        CMD_TTL         = 4'd4,
        CMD_QUIT        = 4'd5,
        CMD_SUBSCRIBE   = 4'd6,
        CMD_UNSUBSCRIBE = 4'd7,
        CMD_PUBLISH     = 4'd8
    } t_cmd;

    // Keyword text, right-justified ASCII.
    function automatic logic [8*KwMaxLen-1:0] kw_text(input logic [2:0] k);
        logic [8*KwMaxLen-1:0] s;
        unique case (k)
            3'd0:    s = (8*KwMaxLen)'("get");
            3'd1:    s = (8*KwMaxLen)'("set");
            3'd2:    s = (8*KwMaxLen)'("del");
            3'd3:    s = (8*KwMaxLen)'("ttl");
            3'd4:    s = (8*KwMaxLen)'("quit");
            3'd5:    s = (8*KwMaxLen)'("subscribe");
            3'd6:    s = (8*KwMaxLen)'("unsubscribe");
            default: s = (8*KwMaxLen)'("publish");
        endcase
        return s;
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            3'd0, 3'd1, 3'd2, 3'd3: n = 4'd3;
            3'd4:                   n = 4'd4;
            3'd5:                   n = 4'd9;
            3'd6:                   n = 4'd11;
            default:                n = 4'd7;
        endcase
        return n;
    endfunction

    // Letter of keyword k at position pos; only meaningful for pos < kw_len(k).
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
        logic [8*KwMaxLen-1:0] s;
        logic [3:0]            idx;
        logic [6:0]            base;
        s    = kw_text(k);
        idx  = 4'(kw_len(k) - 4'd1 - pos);
        base = {idx, 3'b000};
        return s[base +: 8];
    endfunction

endpackage

// ----- hdl/text_command_line_tokenizer_unit.sv -----
// Command line tokenizer: tags each byte by word role and decodes the command word.
//
// Usage:
//   Input stream s_axis: one byte of the command line per transfer, tlast on
//   the final byte of the line. Output stream m_axis: one transfer per input
//   byte, in order, carrying the byte, its role (command, key, value or
//   whitespace), a word-start flag, tlast copied from the input, and on the
//   tlast transfer the command code (0 when the line is empty, the command
//   word is unknown, or the word count, which saturates at three, does not fit the command).
//   A byte accepted on s_axis is presented on m_axis in the next cycle, from
//   the output register. Throughput is one byte per clock while the receiver
//   does not stall; the per-byte work is a single pass of keyword compare
//   logic between the line state registers and the output register.
//   Reset (synchronous, active low) clears the line state and drops any held
//   output. The line state also returns to its reset value after every tlast
//   byte. When the receiver stalls, the output register holds its transfer and
//   s_axis_tready stays high only if that transfer leaves in the same cycle.
`timescale 1ns / 1ps

module text_command_line_tokenizer_unit
    import tclt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [11:8] command_code, [15:12] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] byte_role, [2] word_start
    output logic        m_axis_tlast    // line_done
);

    // line state
    t_kw_mask   r_cand,      n_cand;
    logic [3:0] r_letters,   n_letters;
    logic [1:0] r_words,     n_words;
    logic       r_in_word,   n_in_word;
    t_cmd       r_matched,   n_matched;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    t_role      r_out_role;
    logic       r_out_start;
    logic       r_out_last;
    t_cmd       r_out_cmd;

    logic       in_xfer;
    logic       is_space;
    logic [7:0] lc;
    t_role      role;
    logic       start;
    t_cmd       code;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        is_space  = (s_axis_tdata == 8'h20) ||
                    (s_axis_tdata >= 8'h09 && s_axis_tdata <= 8'h0D);
        lc        = (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5A) ?
                    8'(s_axis_tdata + 8'h20) : s_axis_tdata;
        n_cand    = r_cand;
        n_letters = r_letters;
        n_words   = r_words;
        n_in_word = r_in_word;
        n_matched = r_matched;
        start     = 1'b0;
        role      = ROLE_SPACE;
        code      = CMD_INVALID;

        if (is_space) begin
            n_in_word = 1'b0;
        end else begin
            if (!r_in_word) begin
                start     = 1'b1;
                n_in_word = 1'b1;
                if (r_words != 2'd3) begin
                    n_words = 2'(r_words + 2'd1);
                end
            end
            role = t_role'(2'(n_words - 2'd1));
            if (role == ROLE_COMMAND) begin
                n_matched = CMD_INVALID;
                // each keyword lane compares its own letter independently
                for (int k = 0; k < KwCount; k++) begin
                    if (r_letters >= kw_len(3'(k)) || kw_char(3'(k), r_letters) != lc) begin
                        n_cand[k] = 1'b0;
                    end else if (r_cand[k] && (5'(r_letters) + 5'd1 == 5'(kw_len(3'(k))))) begin
                        n_matched = t_cmd'(4'(k + 1));
                    end
                end
                if (r_letters != 4'd15) begin
                    n_letters = 4'(r_letters + 4'd1);
                end
            end
        end

        if (s_axis_tlast) begin
            // judge the line against the word count its command needs
            if (n_words != 2'd0) begin
                unique case (n_matched)
                    CMD_GET, CMD_DEL, CMD_TTL, CMD_SUBSCRIBE, CMD_UNSUBSCRIBE:
                        code = (n_words == 2'd2) ? n_matched : CMD_INVALID;
                    CMD_SET, CMD_PUBLISH:
                        code = (n_words == 2'd3) ? n_matched : CMD_INVALID;
                    CMD_QUIT:
                        code = n_matched;
                    default:
                        code = CMD_INVALID;
                endcase
            end
            n_cand    = '1;
            n_letters = 4'd0;
            n_words   = 2'd0;
            n_in_word = 1'b0;
            n_matched = CMD_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand    <= '1;
            r_letters <= 4'd0;
            r_words   <= 2'd0;
            r_in_word <= 1'b0;
            r_matched <= CMD_INVALID;
        end else if (in_xfer) begin
            r_cand    <= n_cand;
            r_letters <= n_letters;
            r_words   <= n_words;
            r_in_word <= n_in_word;
            r_matched <= n_matched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_byte  <= s_axis_tdata;
            r_out_role  <= role;
            r_out_start <= start;
            r_out_last  <= s_axis_tlast;
            r_out_cmd   <= code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_cmd, r_out_byte};
    assign m_axis_tuser  = {r_out_start, r_out_role};
    assign m_axis_tlast  = r_out_last;

    // command code appears only on the last byte of a line
    a_cmd_only_at_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_cmd != CMD_INVALID) |-> r_out_last)
        else $error("command code outside end of line");

    // whitespace never starts a word
    a_space_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_role == ROLE_SPACE) |-> !r_out_start)
        else $error("word start flagged on whitespace");

    // line state is back at reset after the final byte
    a_state_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tlast) |=>
        (r_words == 2'd0 && r_letters == 4'd0 && r_cand == '1 && !r_in_word))
        else $error("line state not cleared after end of line");

    // command byte count tracks the candidate mask: past the longest keyword none remain
    a_long_word_no_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_letters > 4'(KwMaxLen)) |-> (r_cand == '0))
        else $error("keyword candidate survives an over-long command word");

    // a word start on a non-command role implies at least two words seen
    a_role_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && start && role != ROLE_COMMAND) |-> (r_words != 2'd0))
        else $error("key or value word without a command word");

endmodule
